// ===== rtl/core/weight_shift_throttle_control_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weight-shift throttle control core
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef WEIGHT_SHIFT_THROTTLE_CONTROL_CORE_MACROS_SVH
`define WEIGHT_SHIFT_THROTTLE_CONTROL_CORE_MACROS_SVH

// Check that an expression holds at every clock edge out of reset
`define WSTC_ASSERT_ALWAYS(label_, expr_) \
	label_: assert property (@(posedge clk) disable iff (!arst_n) (expr_)) \
		else $error("wstc check failed");

// Check that a condition implies a consequence in the same cycle
`define WSTC_ASSERT_IMPLIES(label_, cond_, cons_) \
	label_: assert property (@(posedge clk) disable iff (!arst_n) (cond_) |-> (cons_)) \
		else $error("wstc check failed");

`endif

// ===== rtl/core/wstc_pkg.sv =====
// ---------------------------------------------------------------------------
// wstc_pkg
// Types and fixed-point constants of the weight-shift throttle control core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wstc_pkg;

	// fixed-point formats
	localparam int WEIGHT_FRAC_BITS   = 6;
	localparam int THROTTLE_FRAC_BITS = 16;
	localparam longint ONE            = 64'sd1 << THROTTLE_FRAC_BITS;
	// dead band compare is done in units of 2^-(THROTTLE-WEIGHT) weight
	localparam int DB_SHIFT = THROTTLE_FRAC_BITS - WEIGHT_FRAC_BITS;

	// Q16 constants, rounded to nearest
	localparam longint TH_BAND1   = ((253 * ONE) + 500) / 1000;
	localparam longint TH_BAND2   = ((26 * ONE) + 50) / 100;
	localparam longint TH_BAND3   = ((28 * ONE) + 50) / 100;
	localparam longint STEP1      = ((5 * ONE) + 5000) / 10000;
	localparam longint STEP2      = ((1 * ONE) + 500) / 1000;
	localparam longint STEP3      = ((25 * ONE) + 5000) / 10000;
	localparam longint FLOOR1     = ((1 * ONE) + 2) / 4;
	localparam longint HALF_BRAKE = ((1 * ONE) + 1) / 2;

	// rpm term: round(mag*2^16/210000) = floor((mag*8192 + 13125) / 26250)
	localparam longint RPM_BIAS  = 13125;
	localparam longint RPM_DEN   = 26250;
	localparam int     RPM_SHIFT = 46;
	localparam longint RPM_MULT  = ((64'sd1 << RPM_SHIFT) + RPM_DEN - 1) / RPM_DEN;

	// follow term: round(mag*2^16/320000) = floor((mag*256 + 625) / 1250)
	// magnitudes at or beyond 2^20 saturate the throttle either way
	localparam longint FOL_CAP   = 64'sd1 << 20;
	localparam longint FOL_BIAS  = 625;
	localparam longint FOL_DEN   = 1250;
	localparam int     FOL_SHIFT = 40;
	localparam longint FOL_MULT  = ((64'sd1 << FOL_SHIFT) + FOL_DEN - 1) / FOL_DEN;

	// servo pulse
	localparam longint PULSE_MID  = 1500;
	localparam longint PULSE_GAIN = 500;

	// register indexes
	localparam logic [1:0] CFG_MIN_TOTAL  = 2'd0;
	localparam logic [1:0] CFG_MIN_SINGLE = 2'd1;
	localparam logic [1:0] CFG_DEAD_BAND  = 2'd2;
	localparam logic [1:0] CFG_BRAKE_DIFF = 2'd3;

	// register reset values
	localparam logic [15:0] RST_MIN_TOTAL  = 16'd2560;
	localparam logic [15:0] RST_MIN_SINGLE = 16'd960;
	localparam logic [15:0] RST_DEAD_BAND  = 16'd448;
	localparam logic [15:0] RST_BRAKE_DIFF = 16'd1920;

	typedef struct packed {
		logic [15:0] min_total;
		logic [15:0] min_single;
		logic [15:0] dead_band;
		logic [15:0] brake_diff;
	} wstc_cfg_t;

	// state-independent terms handed from the front stage to the step stage
	typedef struct packed {
		logic               disarm;     // too little load
		logic               diff_pos;   // front heavier than rear
		logic               brake_hit;  // rear lean beyond brake difference
		logic signed [25:0] excess;     // |diff| - dead band at zero throttle
		logic signed [16:0] rpm_term;   // Q16 rpm contribution
		logic signed [18:0] fol_term;   // Q16 follow contribution
	} wstc_pre_t;

endpackage

// ===== rtl/core/wstc_front.sv =====
// ---------------------------------------------------------------------------
// wstc_front
// Input register and the state-independent terms: load checks, dead band
// excess, brake test, and the rpm and follow terms by reciprocal multiply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wstc_pkg::wstc_cfg_t   cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic signed [23:0]    front_weight,
	input  logic signed [23:0]    rear_weight,
	input  logic signed [17:0]    motor_rpm,
	input  logic                  rpm_valid,
	output logic                  pre_valid,
	input  logic                  pre_ready,
	output wstc_pkg::wstc_pre_t   pre
);
	import wstc_pkg::*;

	logic               v_s1;
	logic signed [23:0] front_s1;
	logic signed [23:0] rear_s1;
	logic signed [17:0] rpm_s1;
	logic               rv_s1;
	logic               v_s2;
	wstc_pre_t          pre_s2;
	logic               load_s2;

	logic signed [24:0] sum_w;
	logic signed [24:0] diff_w;
	logic signed [25:0] tot_m;
	logic signed [24:0] front_m;
	logic signed [24:0] rear_m;
	logic [24:0]        absd;
	logic signed [25:0] brk_m;
	logic [17:0]        rpm_mag;
	logic [30:0]        yr;
	logic [62:0]        prod_r;
	logic [16:0]        q_r;
	logic signed [16:0] rpm_term_d;
	logic [20:0]        mag_c;
	logic [28:0]        yf;
	logic [58:0]        prod_f;
	logic [17:0]        q_f;
	logic signed [18:0] fol_term_d;
	wstc_pre_t          pre_d;

	// advance handshake
	assign load_s2  = !v_s2 || pre_ready;
	assign s_tready = !v_s1 || load_s2;

	// hold the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			front_s1 <= front_weight;
			rear_s1  <= rear_weight;
			rpm_s1   <= motor_rpm;
			rv_s1    <= rpm_valid;
		end
	end

	// load checks and dead band excess
	always_comb begin
		sum_w   = 25'(front_s1) + 25'(rear_s1);
		diff_w  = 25'(front_s1) - 25'(rear_s1);
		tot_m   = 26'(sum_w) - $signed({10'b0, cfg.min_total});
		front_m = 25'(front_s1) - $signed({9'b0, cfg.min_single});
		rear_m  = 25'(rear_s1) - $signed({9'b0, cfg.min_single});
		absd    = diff_w[24] ? 25'(-diff_w) : 25'(diff_w);
		brk_m   = 26'(diff_w) + $signed({10'b0, cfg.brake_diff});

		pre_d.disarm    = tot_m[25] || front_m[24] || rear_m[24];
		pre_d.diff_pos  = !diff_w[24] && (diff_w != 25'sd0);
		pre_d.brake_hit = brk_m[25];
		pre_d.excess    = $signed({1'b0, absd}) - $signed({10'b0, cfg.dead_band});
		pre_d.rpm_term  = rpm_term_d;
		pre_d.fol_term  = fol_term_d;
	end

	// rpm term, rounded half away from zero
	always_comb begin
		rpm_mag = rpm_s1[17] ? 18'(-rpm_s1) : 18'(rpm_s1);
		yr      = {rpm_mag, 13'b0} + 31'(RPM_BIAS);
		prod_r  = 63'(yr) * 63'(RPM_MULT);
		q_r     = 17'(prod_r >> RPM_SHIFT);
		if (!rv_s1) begin
			rpm_term_d = 17'sd0;
		end else if (rpm_s1[17]) begin
			rpm_term_d = -$signed(q_r);
		end else begin
			rpm_term_d = $signed(q_r);
		end
	end

	// follow term, magnitude capped where the result saturates anyway
	always_comb begin
		mag_c  = (absd >= 25'(FOL_CAP)) ? 21'(FOL_CAP) : absd[20:0];
		yf     = {mag_c, 8'b0} + 29'(FOL_BIAS);
		prod_f = 59'(yf) * 59'(FOL_MULT);
		q_f    = 18'(prod_f >> FOL_SHIFT);
		fol_term_d = diff_w[24] ? -$signed({1'b0, q_f}) : $signed({1'b0, q_f});
	end

	// register the terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && v_s1) begin
			pre_s2 <= pre_d;
		end
	end

	assign pre_valid = v_s2;
	assign pre       = pre_s2;

endmodule

// ===== rtl/core/wstc_step.sv =====
// ---------------------------------------------------------------------------
// wstc_step
// Throttle and armed state update with the result register: dead band
// compare, throttle bands, brake, clamp and servo pulse width.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "weight_shift_throttle_control_core_macros.svh"

module wstc_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pre_valid,
	output logic                pre_ready,
	input  wstc_pkg::wstc_pre_t pre,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic signed [17:0]  drive_command,
	output logic                riding,
	output logic [10:0]         pulse_width_us
);
	import wstc_pkg::*;

	logic [16:0]        throttle_q;
	logic               armed_q;
	logic               out_v_q;
	logic signed [17:0] cmd_q;
	logic               riding_q;
	logic [10:0]        pulse_q;
	logic               take;

	logic signed [37:0] cmp;
	logic               arm_now;
	logic               lean;
	logic signed [20:0] pz;
	logic signed [20:0] b1;
	logic signed [20:0] p_raw;
	logic               braking;
	logic signed [20:0] cmd_brk;
	logic [16:0]        p_next;
	logic               armed_next;
	logic signed [17:0] cmd_next;
	logic signed [27:0] pw;
	logic signed [11:0] pw_sum;

	assign pre_ready = !out_v_q || m_tready;
	assign take      = pre_valid && pre_ready;

	// dead band compare: |diff|*2^10 against dead_band*2^10 + 3*throttle
	always_comb begin
		pz      = $signed({4'b0, throttle_q});
		cmp     = (38'(pre.excess) <<< DB_SHIFT) - 38'(pz) * 38'sd3;
		arm_now = cmp[37] && !armed_q;
		lean    = !cmp[37] && (cmp != 38'sd0) && armed_q;
	end

	// throttle bands, brake and follow
	always_comb begin
		b1 = pz + 21'(STEP1) + 21'(pre.rpm_term);
		if (b1 < 21'(FLOOR1)) begin
			b1 = 21'(FLOOR1);
		end
		if (pz < 21'(TH_BAND1) && pre.diff_pos) begin
			p_raw = b1;
		end else if (pz < 21'(TH_BAND2) && pre.diff_pos) begin
			p_raw = pz + 21'(STEP2);
		end else if (pz < 21'(TH_BAND3) && pre.diff_pos) begin
			p_raw = pz + 21'(STEP3);
		end else if (pre.brake_hit) begin
			p_raw = -21'(HALF_BRAKE);
		end else begin
			p_raw = pz + 21'(pre.fol_term);
		end
		cmd_brk = (p_raw < -21'(ONE)) ? -21'(ONE) : p_raw;
	end

	// next state and command
	always_comb begin
		braking    = 1'b0;
		armed_next = armed_q;
		p_next     = throttle_q;
		if (pre.disarm) begin
			armed_next = 1'b0;
			p_next     = 17'd0;
		end else if (arm_now) begin
			armed_next = 1'b1;
		end else if (lean) begin
			if (p_raw[20]) begin
				braking = 1'b1;
				p_next  = 17'd0;
			end else if (p_raw > 21'(ONE)) begin
				p_next = 17'(ONE);
			end else begin
				p_next = p_raw[16:0];
			end
		end
		cmd_next = braking ? 18'(cmd_brk) : $signed({1'b0, p_next});
		pw       = 28'(cmd_next) * 28'(PULSE_GAIN);
		pw_sum   = pw[27:16] + 12'(PULSE_MID);
	end

	// advance state with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= 17'd0;
			armed_q    <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (pre_ready) begin
				out_v_q <= pre_valid;
			end
			if (take) begin
				throttle_q <= p_next;
				armed_q    <= armed_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q    <= cmd_next;
			riding_q <= armed_next;
			pulse_q  <= pw_sum[10:0];
		end
	end

	assign m_tvalid       = out_v_q;
	assign drive_command  = cmd_q;
	assign riding         = riding_q;
	assign pulse_width_us = pulse_q;

	`WSTC_ASSERT_ALWAYS(a_throttle_range, throttle_q <= 17'(ONE))
	`WSTC_ASSERT_IMPLIES(a_disarmed_idle, !armed_q, throttle_q == 17'd0)
	`WSTC_ASSERT_IMPLIES(a_brake_zeroes, out_v_q && cmd_q[17], throttle_q == 17'd0)
	`WSTC_ASSERT_IMPLIES(a_pulse_range, out_v_q, (pulse_q >= 11'd1000) && (pulse_q <= 11'd2000))

endmodule

// ===== rtl/core/weight_shift_throttle_control_core.sv =====
// Throughput: one word per cycle while m_tready does not stall the output stream;
// the throttle and armed state update in the same cycle as the result register loads.
// The input register, the term stage and the result register each hold one word.
// Reset (arst_n low) clears throttle, the armed state and all valid flags at once and
// loads the register defaults; no clearing pass follows.
// ---------------------------------------------------------------------------
// weight_shift_throttle_control_core
// Load-cell weight-shift throttle controller with stream ports and a plain
// register write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module weight_shift_throttle_control_core (
	input  logic        clk,
	input  logic        arst_n,
	// register write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // front_weight[23:0], rear_weight[23:0], motor_rpm[17:0], pad
	input  logic        s_tuser,   // rpm_valid
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // drive_command[17:0], riding, pulse_width_us[10:0], pad
);
	import wstc_pkg::*;

	wstc_cfg_t          cfg_q;
	logic               pre_valid;
	logic               pre_ready;
	wstc_pre_t          pre;
	logic signed [17:0] drive_command;
	logic               riding;
	logic [10:0]        pulse_width_us;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_total  <= RST_MIN_TOTAL;
			cfg_q.min_single <= RST_MIN_SINGLE;
			cfg_q.dead_band  <= RST_DEAD_BAND;
			cfg_q.brake_diff <= RST_BRAKE_DIFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_TOTAL:  cfg_q.min_total  <= cfg_data;
				CFG_MIN_SINGLE: cfg_q.min_single <= cfg_data;
				CFG_DEAD_BAND:  cfg_q.dead_band  <= cfg_data;
				CFG_BRAKE_DIFF: cfg_q.brake_diff <= cfg_data;
				default:        cfg_q.brake_diff <= cfg_data;
			endcase
		end
	end

	wstc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.front_weight ($signed(s_tdata[23:0])),
		.rear_weight  ($signed(s_tdata[47:24])),
		.motor_rpm    ($signed(s_tdata[65:48])),
		.rpm_valid    (s_tuser),
		.pre_valid    (pre_valid),
		.pre_ready    (pre_ready),
		.pre          (pre)
	);

	wstc_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.pre_valid      (pre_valid),
		.pre_ready      (pre_ready),
		.pre            (pre),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.drive_command  (drive_command),
		.riding         (riding),
		.pulse_width_us (pulse_width_us)
	);

	// pack the result word
	assign m_tdata = {2'b00, pulse_width_us, riding, drive_command};

endmodule
